[rtl/slrg_pkg.sv]
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared types and constants of the shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

	localparam int unsigned VAL_W = 31;
	localparam int unsigned MULT_W = 15;

	typedef logic [VAL_W-1:0] word_t;

	localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;
	localparam word_t LCG_MOD = 31'h7FFF_FFFF;
	localparam int unsigned WARMUP_EXTRA = 8;

endpackage

[rtl/shuffled_lehmer_random_generator_unit.sv]
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_unit
// Minimal standard Lehmer generator feeding a Bays-Durham shuffle table
// held in a synchronous memory.
// ----------------------------------------------------------------------------
// draw: request taken in idle (table read), result registered in write-back,
//   held while the sample output stalls; no new request until it is done
// reseed (or first draw after reset): seed load, TABLE_DEPTH + 8 warm-up steps
//   at one per cycle (table writes in the last TABLE_DEPTH), then a draw
// reset: generator state 1, shuffle output 0 (unseeded); table not cleared
module shuffled_lehmer_random_generator_unit #(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  logic            mode,
	input  slrg_pkg::word_t seed,
	output logic            smp_valid,
	input  logic            smp_stall,
	output slrg_pkg::word_t sample
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned TOTAL = TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA;
	localparam int unsigned CNT_W = $clog2(TOTAL);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SEED = 3'd1;
	localparam logic [2:0] ST_SIDX = 3'd2;
	localparam logic [2:0] ST_DRAW = 3'd3;
	localparam logic [2:0] ST_WB   = 3'd4;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	slrg_pkg::word_t   lehmer_q;
	slrg_pkg::word_t   shuf_q;
	slrg_pkg::word_t   sample_q;
	logic              smp_valid_q;

	slrg_pkg::word_t   tbl_mem [TABLE_DEPTH];
	slrg_pkg::word_t   rd_q;

	slrg_pkg::word_t   lehmer_nxt;
	slrg_pkg::word_t   idx_src;
	logic [IDX_W-1:0]  idx_calc;
	slrg_pkg::word_t   seed_val;
	logic              req_acc;
	logic              need_seed;
	logic              wb_go;
	logic              mem_re;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	slrg_pkg::word_t   mem_wdata;

	slrg_lehmer u_lehmer (
		.x      (lehmer_q),
		.x_next (lehmer_nxt)
	);

	assign idx_src = (state_q == ST_WB) ? rd_q : shuf_q;

	slrg_index #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W)
	) u_index (
		.value (idx_src),
		.idx   (idx_calc)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc = req_valid && !req_stall;
	assign need_seed = mode || (shuf_q == '0);
	assign wb_go = (state_q == ST_WB) && (!smp_valid_q || !smp_stall);

	always_comb begin
		if (mode && (seed != '0)) begin
			seed_val = seed;
		end else begin
			seed_val = slrg_pkg::VAL_W'(1);
		end
	end

	// table read for a draw, either straight from idle or after seeding
	assign mem_re = (req_acc && !need_seed) || (state_q == ST_DRAW);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = lehmer_q;
		if ((state_q == ST_SEED) && (cnt_q < CNT_W'(TABLE_DEPTH))) begin
			mem_we = 1'b1;
			mem_waddr = cnt_q[IDX_W-1:0];
			mem_wdata = lehmer_nxt;
		end else if (wb_go) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= tbl_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			lehmer_q <= slrg_pkg::VAL_W'(1);
			shuf_q <= '0;
			smp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (need_seed) begin
							lehmer_q <= seed_val;
							cnt_q <= CNT_W'(TOTAL - 1);
							state_q <= ST_SEED;
						end else begin
							lehmer_q <= lehmer_nxt;
							state_q <= ST_WB;
						end
					end
				end
				ST_SEED: begin
					lehmer_q <= lehmer_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						// entry 0 is the last value written
						shuf_q <= lehmer_nxt;
						state_q <= ST_SIDX;
					end
				end
				ST_SIDX: begin
					idx_q <= idx_calc;
					state_q <= ST_DRAW;
				end
				ST_DRAW: begin
					lehmer_q <= lehmer_nxt;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_go) begin
						shuf_q <= rd_q;
						idx_q <= idx_calc;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (wb_go) begin
				smp_valid_q <= 1'b1;
			end else if (!smp_stall) begin
				smp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			sample_q <= rd_q;
		end
	end

	assign smp_valid = smp_valid_q;
	assign sample = sample_q;

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < IDX_W'(TABLE_DEPTH - 1) || idx_q == IDX_W'(TABLE_DEPTH - 1))
		else $error("table index beyond depth");

	a_seed_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED) |-> (cnt_q < CNT_W'(TOTAL - 1) || cnt_q == CNT_W'(TOTAL - 1)))
		else $error("warm-up counter out of range");

	a_reseed_path: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && mode) |=> (state_q == ST_SEED))
		else $error("reseed request did not start seeding");

	a_wb_result: assert property (@(posedge clk) disable iff (!arst_n)
		wb_go |=> (smp_valid && state_q == ST_IDLE))
		else $error("write-back did not present a result");

	a_no_read_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) |-> !mem_re)
		else $error("table read overlaps pending write-back");
`endif

endmodule

[rtl/slrg_lehmer.sv]
// ----------------------------------------------------------------------------
// slrg_lehmer
// One step of the minimal standard generator: 16807 * x mod (2^31 - 1).
// ----------------------------------------------------------------------------
module slrg_lehmer (
	input  slrg_pkg::word_t x,
	output slrg_pkg::word_t x_next
);

	localparam int unsigned PROD_W = slrg_pkg::VAL_W + slrg_pkg::MULT_W;

	logic [PROD_W-1:0] prod;
	logic [slrg_pkg::VAL_W:0] fold;

	assign prod = PROD_W'(x) * PROD_W'(slrg_pkg::LCG_MULT);

	// 2^31 is 1 mod 2^31-1: add the high part back onto the low part
	assign fold = {1'b0, prod[slrg_pkg::VAL_W-1:0]}
		+ (slrg_pkg::VAL_W+1)'(prod[PROD_W-1:slrg_pkg::VAL_W]);

	always_comb begin
		if (fold >= {1'b0, slrg_pkg::LCG_MOD}) begin
			x_next = slrg_pkg::VAL_W'(fold - {1'b0, slrg_pkg::LCG_MOD});
		end else begin
			x_next = fold[slrg_pkg::VAL_W-1:0];
		end
	end

endmodule

[rtl/slrg_index.sv]
// ----------------------------------------------------------------------------
// slrg_index
// Shuffle table index: shuffled value divided by 1 + (2^31 - 2) / depth,
// by an exact reciprocal multiply, saturated at the last entry.
// ----------------------------------------------------------------------------
module slrg_index #(
	parameter int unsigned TABLE_DEPTH = 32,
	parameter int unsigned IDX_W = 5
) (
	input  slrg_pkg::word_t   value,
	output logic [IDX_W-1:0]  idx
);

	localparam longint unsigned SEL_DIV =
		64'd1 + (64'(slrg_pkg::LCG_MOD) - 64'd1) / 64'(TABLE_DEPTH);
	localparam int unsigned SEL_LOG = $clog2(SEL_DIV);
	localparam int unsigned SHIFT = slrg_pkg::VAL_W + SEL_LOG;
	// ceil(2^SHIFT / SEL_DIV) fits in 33 bits and is exact for 31-bit inputs
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + SEL_DIV - 64'd1) / SEL_DIV;
	localparam int unsigned RECIP_W = 33;

	logic [63:0] prod;
	logic [63:0] quo;

	assign prod = 64'(value) * 64'(RECIP[RECIP_W-1:0]);
	assign quo = prod >> SHIFT;

	always_comb begin
		if (quo >= 64'(TABLE_DEPTH)) begin
			idx = IDX_W'(TABLE_DEPTH - 1);
		end else begin
			idx = quo[IDX_W-1:0];
		end
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the shuffled Lehmer random generator: directed
// seeds (zero, one, the modulus itself, bit patterns), an unseeded first
// draw, a long sample hold-off and a random draw/reseed stream, each sample
// compared with an in-bench model of the generator and its shuffle table.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned TABLE_DEPTH = 32;
	localparam logic MODE_DRAW = 1'b0;
	localparam logic MODE_RESEED = 1'b1;
	localparam longint unsigned SEL_DIV =
		1 + (longint'(slrg_pkg::LCG_MOD) - 1) / TABLE_DEPTH;

	logic            clk;
	logic            arst_n;
	logic            req_valid;
	logic            req_stall;
	logic            mode;
	slrg_pkg::word_t seed;
	logic            smp_valid;
	logic            smp_stall;
	slrg_pkg::word_t sample;

	// model state of the generator
	slrg_pkg::word_t lehmer_x;
	slrg_pkg::word_t shuf_out;
	slrg_pkg::word_t shuf_tab [TABLE_DEPTH];

	slrg_pkg::word_t expected_samples [$];

	int unsigned errors;
	int unsigned n_requests;
	int unsigned n_reseeds;
	int unsigned n_checked;
	int unsigned n_zero;
	bit req_idle_en;
	bit smp_idle_en;
	int unsigned long_hold;

	shuffled_lehmer_random_generator_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.mode(mode),
		.seed(seed),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.sample(sample)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic slrg_pkg::word_t lehmer_advance(slrg_pkg::word_t x);
		longint unsigned p;
		p = longint'(slrg_pkg::LCG_MULT) * longint'(x);
		return slrg_pkg::word_t'(p % longint'(slrg_pkg::LCG_MOD));
	endfunction

	// warm-up steps, the last TABLE_DEPTH of them fill the table top down
	function automatic void reload_table(slrg_pkg::word_t s);
		slrg_pkg::word_t x;
		x = (s == '0) ? slrg_pkg::word_t'(1) : s;
		for (int unsigned n = TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA; n > 0; n--) begin
			x = lehmer_advance(x);
			if (n - 1 < TABLE_DEPTH)
				shuf_tab[n-1] = x;
		end
		lehmer_x = x;
		shuf_out = shuf_tab[0];
	endfunction

	function automatic slrg_pkg::word_t next_sample(logic m, slrg_pkg::word_t s);
		longint unsigned idx;
		if (m == MODE_RESEED) begin
			reload_table(s);
			n_reseeds++;
		end else if (shuf_out == '0) begin
			// unseeded or stuck at zero: seeds from one
			reload_table(slrg_pkg::word_t'(1));
			n_reseeds++;
		end
		lehmer_x = lehmer_advance(lehmer_x);
		idx = longint'(shuf_out) / SEL_DIV;
		if (idx >= TABLE_DEPTH)
			idx = TABLE_DEPTH - 1;
		shuf_out = shuf_tab[idx];
		shuf_tab[idx] = lehmer_x;
		return shuf_out;
	endfunction

	function automatic int unsigned idle_burst(bit en);
		if (en && $urandom_range(0, 3) == 0)
			return $urandom_range(1, 19);
		return 0;
	endfunction

	task automatic send_request(logic m, slrg_pkg::word_t s);
		int unsigned gap;
		gap = idle_burst(req_idle_en);
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		mode <= m;
		seed <= s;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_requests++;
		expected_samples.push_back(next_sample(m, s));
	endtask

	// receiver: random hold bursts, plus a long hold when a test asks for one
	initial begin : sample_sink
		int unsigned n;
		smp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold != 0) begin
				n = long_hold;
				long_hold = 0;
			end else begin
				n = idle_burst(smp_idle_en);
			end
			if (n != 0) begin
				smp_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			smp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && smp_valid && !smp_stall) begin
			slrg_pkg::word_t want;
			if (expected_samples.size() == 0) begin
				$error("sample: no request pending, actual %0d", sample);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				n_checked++;
				if (want == '0)
					n_zero++;
				if (sample !== want) begin
					$error("sample: expected %0d actual %0d", want, sample);
					errors++;
				end
			end
		end
	end

	task automatic test_unseeded_draw();
		// seed field is ignored on a draw, the first one seeds from one
		send_request(MODE_DRAW, slrg_pkg::LCG_MOD);
		send_request(MODE_DRAW, '0);
		send_request(MODE_DRAW, slrg_pkg::word_t'($urandom()));
	endtask

	task automatic test_seed_extremes();
		send_request(MODE_RESEED, '0);
		send_request(MODE_DRAW, '0);
		send_request(MODE_RESEED, slrg_pkg::word_t'(1));
		send_request(MODE_RESEED, slrg_pkg::LCG_MOD - 31'd1);
		send_request(MODE_DRAW, slrg_pkg::LCG_MOD);
		// modulus seed collapses the generator to zero
		send_request(MODE_RESEED, slrg_pkg::LCG_MOD);
		send_request(MODE_DRAW, slrg_pkg::LCG_MOD);
		send_request(MODE_DRAW, '0);
		send_request(MODE_RESEED, slrg_pkg::LCG_MOD);
		send_request(MODE_RESEED, slrg_pkg::word_t'(31'h5555_5555));
		send_request(MODE_DRAW, slrg_pkg::word_t'(31'h2AAA_AAAA));
		send_request(MODE_RESEED, slrg_pkg::word_t'(31'h2AAA_AAAA));
		send_request(MODE_DRAW, slrg_pkg::word_t'(31'h5555_5555));
		send_request(MODE_DRAW, '0);
	endtask

	task automatic test_backpressure();
		req_idle_en = 1'b0;
		long_hold = 300;
		for (int unsigned i = 0; i < 30; i++)
			send_request(MODE_DRAW, slrg_pkg::word_t'($urandom()));
		req_idle_en = 1'b1;
	endtask

	task automatic test_random_stream(int unsigned count);
		logic            m;
		slrg_pkg::word_t s;
		for (int unsigned i = 0; i < count; i++) begin
			if (i == count - count / 8) begin
				req_idle_en = 1'b0;
				smp_idle_en = 1'b0;
			end
			m = ($urandom_range(0, 31) == 0) ? MODE_RESEED : MODE_DRAW;
			case ($urandom_range(0, 15))
				0: s = '0;
				1: s = slrg_pkg::LCG_MOD;
				default: s = slrg_pkg::word_t'($urandom());
			endcase
			send_request(m, s);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		mode = MODE_DRAW;
		seed = '0;
		errors = 0;
		n_requests = 0;
		n_reseeds = 0;
		n_checked = 0;
		n_zero = 0;
		req_idle_en = 1'b1;
		smp_idle_en = 1'b1;
		long_hold = 0;
		lehmer_x = slrg_pkg::word_t'(1);
		shuf_out = '0;
		foreach (shuf_tab[i])
			shuf_tab[i] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_unseeded_draw();
		test_seed_extremes();
		test_backpressure();
		test_random_stream(1800);

		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (expected_samples.size() != 0) begin
			$error("sample: %0d requests without a result", expected_samples.size());
			errors++;
		end

		$display("covered %0d requests, %0d of them reseeding the table", n_requests, n_reseeds);
		$display("checked %0d samples, %0d from a collapsed generator", n_checked, n_zero);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
